FILE: hdl/brf_pkg.sv
// Shared definitions for the mode-banked register file: command codes,
// mode codes, bank bases and the bank / saved-status decode functions.
// No dependencies.
`timescale 1ns / 1ps

package brf_pkg;

  // Bank store geometry
  localparam int BANK_DEPTH_DEF = 96;
  localparam int BANK_AW        = $clog2(BANK_DEPTH_DEF);
  localparam int SPSR_COUNT     = 5;
  localparam int SPSR_AW        = $clog2(SPSR_COUNT);

  typedef logic [BANK_AW-1:0] bank_addr_t;
  typedef logic [SPSR_AW-1:0] spsr_idx_t;

  // Access commands
  typedef enum logic [2:0] {
    CMD_RD_REG  = 3'd0,
    CMD_WR_REG  = 3'd1,
    CMD_RD_CPSR = 3'd2,
    CMD_WR_CPSR = 3'd3,
    CMD_RD_SPSR = 3'd4,
    CMD_WR_SPSR = 3'd5
  } cmd_t;

  // Processor mode codes
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Bank bases in the bank store
  localparam bank_addr_t BASE_USR = BANK_AW'(0);
  localparam bank_addr_t BASE_SVC = BANK_AW'(16);
  localparam bank_addr_t BASE_ABT = BANK_AW'(32);
  localparam bank_addr_t BASE_UND = BANK_AW'(48);
  localparam bank_addr_t BASE_IRQ = BANK_AW'(64);
  localparam bank_addr_t BASE_FIQ = BANK_AW'(80);

  // Saved-status slots
  localparam spsr_idx_t SLOT_FIQ = SPSR_AW'(0);
  localparam spsr_idx_t SLOT_IRQ = SPSR_AW'(1);
  localparam spsr_idx_t SLOT_SVC = SPSR_AW'(2);
  localparam spsr_idx_t SLOT_ABT = SPSR_AW'(3);
  localparam spsr_idx_t SLOT_UND = SPSR_AW'(4);

  typedef struct packed {
    logic       hit;
    bank_addr_t base;
  } bank_sel_t;

  typedef struct packed {
    logic      hit;
    spsr_idx_t slot;
  } spsr_sel_t;

  // Pick the bank base for a register in a mode; hit clear when invalid
  function automatic bank_sel_t bank_lookup(input logic [3:0] reg_n,
                                            input logic [4:0] mode);
    bank_sel_t sel;
    sel.hit  = 1'b1;
    sel.base = BASE_USR;
    if (reg_n <= 4'd7 || reg_n == 4'd15) begin
      sel.base = BASE_USR;
    end else if (reg_n <= 4'd12) begin
      unique case (mode) inside
        MODE_FIQ: sel.base = BASE_FIQ;
        MODE_USR, MODE_SYS, MODE_SVC, MODE_ABT, MODE_UND, MODE_IRQ:
          sel.base = BASE_USR;
        default: sel.hit = 1'b0;
      endcase
    end else begin
      unique case (mode) inside
        MODE_USR, MODE_SYS: sel.base = BASE_USR;
        MODE_SVC: sel.base = BASE_SVC;
        MODE_ABT: sel.base = BASE_ABT;
        MODE_UND: sel.base = BASE_UND;
        MODE_IRQ: sel.base = BASE_IRQ;
        MODE_FIQ: sel.base = BASE_FIQ;
        default:  sel.hit  = 1'b0;
      endcase
    end
    return sel;
  endfunction

  // Pick the saved-status slot of an exception mode
  function automatic spsr_sel_t spsr_lookup(input logic [4:0] mode);
    spsr_sel_t sel;
    sel.hit  = 1'b1;
    sel.slot = SLOT_FIQ;
    unique case (mode)
      MODE_FIQ: sel.slot = SLOT_FIQ;
      MODE_IRQ: sel.slot = SLOT_IRQ;
      MODE_SVC: sel.slot = SLOT_SVC;
      MODE_ABT: sel.slot = SLOT_ABT;
      MODE_UND: sel.slot = SLOT_UND;
      default:  sel.hit  = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

FILE: hdl/banked_register_file.sv
// Top level of the mode-banked register file: access decode, CPSR and
// SPSR registers, output stage. Depends on brf_pkg and brf_bank_mem.
`timescale 1ns / 1ps

// Takes one access per clock and returns its result in the cycle after the
// input transfer, from an output register; the input stalls only while
// that register holds a result the consumer has not taken. General
// registers live in a single-port bank store with a registered read, so
// each access touches it at most once and back-to-back accesses need no
// forwarding. The mode flags on a result reflect the CPSR after that
// access, including a CPSR write made by the same access.
module banked_register_file
  import brf_pkg::*;
#(
  parameter int BANK_DEPTH = BANK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [3:0]  reg_num,
  input  logic [4:0]  mode_sel,
  input  logic [31:0] write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        access_ok,
  output logic        cur_privileged,
  output logic        cur_has_spsr
);

  localparam int AW = $clog2(BANK_DEPTH);

  logic        accept;
  bank_sel_t   bsel;
  spsr_sel_t   ssel;
  logic [AW-1:0] bank_addr;
  logic        bank_rd;
  logic        bank_wr;
  logic [31:0] bank_rdata;

  logic [31:0] cpsr;
  logic [31:0] cpsr_next;
  logic [31:0] spsr [SPSR_COUNT];
  spsr_sel_t   cur_sel;

  logic        ok_next;
  logic        from_mem_next;
  logic [31:0] rd_next;
  logic        spsr_wr;

  logic        o_from_mem;
  logic [31:0] o_rd;

  // Hold the input while a result waits downstream
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign bsel      = bank_lookup(reg_num, mode_sel);
  assign ssel      = spsr_lookup(mode_sel);
  assign bank_addr = AW'(bsel.base) + AW'(reg_num);

  // Decode the access
  always_comb begin
    ok_next       = 1'b0;
    from_mem_next = 1'b0;
    rd_next       = 32'd0;
    bank_rd       = 1'b0;
    bank_wr       = 1'b0;
    spsr_wr       = 1'b0;
    cpsr_next     = cpsr;
    unique case (cmd)
      CMD_RD_REG: begin
        ok_next       = bsel.hit;
        from_mem_next = bsel.hit;
        bank_rd       = accept & bsel.hit;
      end
      CMD_WR_REG: begin
        ok_next = bsel.hit;
        bank_wr = accept & bsel.hit;
      end
      CMD_RD_CPSR: begin
        ok_next = 1'b1;
        rd_next = cpsr;
      end
      CMD_WR_CPSR: begin
        ok_next = 1'b1;
        if (accept) begin
          cpsr_next = write_value;
        end
      end
      CMD_RD_SPSR: begin
        ok_next = ssel.hit;
        if (ssel.hit) begin
          rd_next = spsr[ssel.slot];
        end
      end
      CMD_WR_SPSR: begin
        ok_next = ssel.hit;
        spsr_wr = accept & ssel.hit;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  brf_bank_mem #(
    .DEPTH (BANK_DEPTH),
    .AW    (AW)
  ) u_bank (
    .clk   (clk),
    .rst   (rst),
    .rd_en (bank_rd),
    .wr_en (bank_wr),
    .addr  (bank_addr),
    .wdata (write_value),
    .rdata (bank_rdata)
  );

  // CPSR and SPSR registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cpsr <= 32'd0;
      for (int i = 0; i < SPSR_COUNT; i++) begin
        spsr[i] <= 32'd0;
      end
    end else begin
      cpsr <= cpsr_next;
      if (spsr_wr) begin
        spsr[ssel.slot] <= write_value;
      end
    end
  end

  assign cur_sel = spsr_lookup(cpsr_next[4:0]);

  // Output stage: advance on transfer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_from_mem     <= from_mem_next;
      o_rd           <= rd_next;
      access_ok      <= ok_next;
      cur_has_spsr   <= cur_sel.hit;
      cur_privileged <= cur_sel.hit | (cpsr_next[4:0] == MODE_SYS);
    end
  end

  assign read_data = o_from_mem ? bank_rdata : o_rd;

endmodule

FILE: hdl/brf_bank_mem.sv
// Single-port bank store with a registered read and per-entry valid bits.
// An entry never written reads as zero. Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_bank_mem
  import brf_pkg::*;
#(
  parameter int DEPTH = BANK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [31:0]      mem_q;
  logic             written_q;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      mem_q <= mem[addr];
    end
  end

  // Track which entries hold data since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[addr];
      end
    end
  end

  assign rdata = written_q ? mem_q : 32'd0;

endmodule

FILE: sim/tb_banked_register_file.sv
// Testbench for banked_register_file: directed and random register, CPSR and
// SPSR accesses with random stalls on both sides, checked against a shadow model.
// Depends on brf_pkg and the banked_register_file RTL.
`timescale 1ns / 1ps

module tb_banked_register_file
  import brf_pkg::*;
();

  // Command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Mode codes outside the architected set
  localparam logic [4:0] MODE_NONE = 5'h00;
  localparam logic [4:0] MODE_RSVD = 5'h1E;

  localparam int RANDOM_ITEMS   = 340;
  localparam int CLEAN_ITEMS    = 60;
  localparam int PRESSURE_ITEMS = 24;
  localparam int HOLD_CYCLES    = 120;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 5;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        cur_privileged;
    logic        cur_has_spsr;
  } access_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [3:0]  reg_num;
  logic [4:0]  mode_sel;
  logic [31:0] write_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        access_ok;
  logic        cur_privileged;
  logic        cur_has_spsr;

  // Shadow copy of the architectural state
  logic [31:0] shadow_bank [BANK_DEPTH_DEF];
  logic [31:0] shadow_cpsr;
  logic [31:0] shadow_spsr [SPSR_COUNT];

  access_result_t pending_results[$];
  int errors;
  int results_checked;
  int rejected_count;
  int quiet_cycles;
  int cmd_count [8];
  bit sender_gaps;
  bit receiver_stalls;
  bit hold_off_req;

  banked_register_file dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .reg_num        (reg_num),
    .mode_sel       (mode_sel),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .access_ok      (access_ok),
    .cur_privileged (cur_privileged),
    .cur_has_spsr   (cur_has_spsr)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Map a register and mode to its bank store entry; -1 when the pair is invalid
  function automatic int bank_entry(input logic [3:0] r, input logic [4:0] m);
    bank_addr_t base;
    if (r <= 4'd7 || r == 4'd15) return int'(r);
    case (m) inside
      MODE_FIQ:           return int'(BASE_FIQ) + int'(r);
      MODE_USR, MODE_SYS: return int'(r);
      MODE_SVC:           base = BASE_SVC;
      MODE_ABT:           base = BASE_ABT;
      MODE_UND:           base = BASE_UND;
      MODE_IRQ:           base = BASE_IRQ;
      default:            return -1;
    endcase
    // R8-R12 are shared by every mode but FIQ
    return (r <= 4'd12) ? int'(r) : int'(base) + int'(r);
  endfunction

  // Saved-status slot of an exception mode; -1 for modes without one
  function automatic int status_slot(input logic [4:0] m);
    case (m)
      MODE_FIQ: return int'(SLOT_FIQ);
      MODE_IRQ: return int'(SLOT_IRQ);
      MODE_SVC: return int'(SLOT_SVC);
      MODE_ABT: return int'(SLOT_ABT);
      MODE_UND: return int'(SLOT_UND);
      default:  return -1;
    endcase
  endfunction

  // Perform one access on the shadow state and return its result
  function automatic access_result_t apply_access(input logic [2:0] c, input logic [3:0] r,
                                                  input logic [4:0] m, input logic [31:0] v);
    access_result_t res;
    int entry;
    int slot;
    logic [4:0] cur;
    res = '0;
    entry = bank_entry(r, m);
    slot = status_slot(m);
    case (c)
      CMD_RD_REG: if (entry >= 0) begin
        res.access_ok = 1'b1;
        res.read_data = shadow_bank[entry];
      end
      CMD_WR_REG: if (entry >= 0) begin
        res.access_ok = 1'b1;
        shadow_bank[entry] = v;
      end
      CMD_RD_CPSR: begin
        res.access_ok = 1'b1;
        res.read_data = shadow_cpsr;
      end
      CMD_WR_CPSR: begin
        res.access_ok = 1'b1;
        shadow_cpsr = v;
      end
      CMD_RD_SPSR: if (slot >= 0) begin
        res.access_ok = 1'b1;
        res.read_data = shadow_spsr[slot];
      end
      CMD_WR_SPSR: if (slot >= 0) begin
        res.access_ok = 1'b1;
        shadow_spsr[slot] = v;
      end
      default: ;
    endcase
    // Mode flags follow the CPSR after this access
    cur = shadow_cpsr[4:0];
    res.cur_has_spsr   = status_slot(cur) >= 0;
    res.cur_privileged = res.cur_has_spsr || cur == MODE_SYS;
    return res;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  // Predict on each input transfer, check each output transfer, watch for hangs
  always @(posedge clk) begin
    access_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = apply_access(cmd, reg_num, mode_sel, write_value);
        pending_results.push_back(want);
        cmd_count[cmd]++;
        if (!want.access_ok) rejected_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result with nothing pending, read_data %h", read_data));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          check_field("read_data", read_data, want.read_data);
          check_field("access_ok", 32'(access_ok), 32'(want.access_ok));
          check_field("cur_privileged", 32'(cur_privileged), 32'(want.cur_privileged));
          check_field("cur_has_spsr", 32'(cur_has_spsr), 32'(want.cur_has_spsr));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                   QUIET_LIMIT, pending_results.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Consumer: random stall bursts, plus one long hold-off on request
  initial begin : consumer
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one access, with an optional idle burst first; return once it transfers
  task automatic send_access(input logic [2:0] c, input logic [3:0] r,
                             input logic [4:0] m, input logic [31:0] v);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid    = 1'b1;
    cmd         = c;
    reg_num     = r;
    mode_sel    = m;
    write_value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly architected modes, sometimes any five-bit code
  function automatic logic [4:0] pick_mode();
    case ($urandom_range(0, 7))
      0:       return MODE_USR;
      1:       return MODE_FIQ;
      2:       return MODE_IRQ;
      3:       return MODE_SVC;
      4:       return MODE_ABT;
      5:       return MODE_UND;
      6:       return MODE_SYS;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic send_random_access();
    logic [2:0]  c;
    logic [31:0] v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      c = CMD_RD_REG;
    else if (pick < 58) c = CMD_WR_REG;
    else if (pick < 66) c = CMD_RD_CPSR;
    else if (pick < 74) c = CMD_WR_CPSR;
    else if (pick < 84) c = CMD_RD_SPSR;
    else if (pick < 94) c = CMD_WR_SPSR;
    else if (pick < 97) c = CMD_SPARE_6;
    else                c = CMD_SPARE_7;
    v = $urandom;
    // Steer most CPSR writes to a real mode so the banks switch
    if (c == CMD_WR_CPSR && $urandom_range(0, 3) != 0) v[4:0] = pick_mode();
    send_access(c, 4'($urandom_range(0, 15)), pick_mode(), v);
  endtask

  task automatic test_reset_state();
    send_access(CMD_RD_CPSR, 4'd0, MODE_NONE, 32'h0);
    send_access(CMD_RD_REG, 4'd13, MODE_USR, 32'h0);
  endtask

  // R0-R7 and R15 ignore the mode, even an invalid one
  task automatic test_shared_regs();
    send_access(CMD_WR_REG, 4'd0, MODE_NONE, 32'hFFFF_FFFF);
    send_access(CMD_RD_REG, 4'd0, MODE_SYS, 32'h0);
    send_access(CMD_WR_REG, 4'd15, MODE_RSVD, 32'hA5A5_5A5A);
    send_access(CMD_RD_REG, 4'd15, MODE_FIQ, 32'h0);
  endtask

  // FIQ-only copies of R8-R12, per-mode R13-R14, rejection on invalid modes
  task automatic test_banked_regs();
    send_access(CMD_WR_REG, 4'd8, MODE_FIQ, 32'h1234_5678);
    send_access(CMD_RD_REG, 4'd8, MODE_USR, 32'h0);
    send_access(CMD_RD_REG, 4'd8, MODE_FIQ, 32'h0);
    send_access(CMD_WR_REG, 4'd14, MODE_SVC, 32'hFFFF_FFFF);
    send_access(CMD_RD_REG, 4'd14, MODE_SYS, 32'h0);
    send_access(CMD_WR_REG, 4'd13, MODE_NONE, 32'hDEAD_BEEF);
    send_access(CMD_RD_REG, 4'd12, MODE_RSVD, 32'h0);
  endtask

  // CPSR writes update the mode flags at once; SPSR only for exception modes
  task automatic test_status_regs();
    send_access(CMD_WR_CPSR, 4'd0, MODE_NONE, 32'hFFFF_FFFF);
    send_access(CMD_WR_CPSR, 4'd0, MODE_NONE, {27'h0, MODE_UND});
    send_access(CMD_RD_CPSR, 4'd0, MODE_NONE, 32'h0);
    send_access(CMD_WR_SPSR, 4'd0, MODE_USR, 32'h5555_5555);
    send_access(CMD_WR_SPSR, 4'd0, MODE_UND, 32'hFFFF_FFFF);
    send_access(CMD_RD_SPSR, 4'd0, MODE_UND, 32'h0);
    send_access(CMD_RD_SPSR, 4'd0, MODE_SYS, 32'h0);
    send_access(CMD_WR_CPSR, 4'd0, MODE_NONE, 32'h0);
  endtask

  task automatic test_spare_cmds();
    send_access(CMD_SPARE_6, 4'd3, MODE_FIQ, 32'hFFFF_FFFF);
    send_access(CMD_SPARE_7, 4'd15, MODE_SYS, 32'h0);
  endtask

  // Hold the consumer off while accesses keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    for (i = 0; i < PRESSURE_ITEMS; i++) send_random_access();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_mix();
    int i;
    for (i = 0; i < RANDOM_ITEMS; i++) send_random_access();
  endtask

  // Finish at full rate with no idling on either side
  task automatic test_full_rate();
    int i;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    for (i = 0; i < CLEAN_ITEMS; i++) send_random_access();
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    cmd             = CMD_RD_REG;
    reg_num         = 4'd0;
    mode_sel        = MODE_NONE;
    write_value     = 32'h0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < BANK_DEPTH_DEF; i++) shadow_bank[i] = 32'h0;
    for (int i = 0; i < SPSR_COUNT; i++) shadow_spsr[i] = 32'h0;
    shadow_cpsr = 32'h0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_shared_regs();
    test_banked_regs();
    test_status_regs();
    test_spare_cmds();
    test_backpressure();
    test_random_mix();
    test_full_rate();

    // Drain the remaining results
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d register, %0d CPSR, %0d SPSR and %0d unused-code accesses, %0d rejected",
             cmd_count[CMD_RD_REG] + cmd_count[CMD_WR_REG],
             cmd_count[CMD_RD_CPSR] + cmd_count[CMD_WR_CPSR],
             cmd_count[CMD_RD_SPSR] + cmd_count[CMD_WR_SPSR],
             cmd_count[CMD_SPARE_6] + cmd_count[CMD_SPARE_7], rejected_count);
    $display("Checked %0d results with random stalls and one long hold-off, %0d mismatches",
             results_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/brf_pkg.sv
hdl/brf_bank_mem.sv
hdl/banked_register_file.sv
sim/tb_banked_register_file.sv
